/* src/rcap_pkg.sv */
// ----------------------------------------------------------------------------
// rcap_pkg
// Shared types and constants for the command array parser.
// ----------------------------------------------------------------------------
package rcap_pkg;

    localparam int ByteW   = 8;
    localparam int NumW    = 30;
    localparam int AccW    = NumW + 4;
    localparam int KindW   = 2;
    localparam int TDataW  = ((ByteW + NumW + 7) / 8) * 8;

    localparam logic [NumW-1:0] MaxNumberReset = NumW'(1000000000);

    localparam logic [KindW-1:0] KIND_DATA    = 2'd0;
    localparam logic [KindW-1:0] KIND_ARG_END = 2'd1;
    localparam logic [KindW-1:0] KIND_ERROR   = 2'd2;

    localparam logic [ByteW-1:0] CHAR_STAR   = 8'h2A;
    localparam logic [ByteW-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [ByteW-1:0] CHAR_CR     = 8'h0D;
    localparam logic [ByteW-1:0] CHAR_LF     = 8'h0A;
    localparam logic [ByteW-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [ByteW-1:0] CHAR_NINE   = 8'h39;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] arg_byte;
        logic [NumW-1:0]  arg_number;
        logic             command_done;
    } result_t;

endpackage

/* src/resp_command_array_parser.sv */
// ----------------------------------------------------------------------------
// resp_command_array_parser
// Byte-stream parser for command arrays of length-prefixed arguments.
//
// The slave channel takes one stream byte per request, with tuser as the
// restart flag that clears the parser before that byte. The master channel
// returns argument data bytes, argument ends (tlast on the final argument of
// a command) and protocol errors, told apart by tuser. A byte that ends a
// trailer, carries data or breaks the format gives one result; other bytes
// give none. After an error no results come until a restart request.
// A byte request passes through the input register and the result register to
// the master side; one byte is taken every cycle while the receiver does not stall.
// The cap register is written through cfg_wr_en / cfg_wr_data at any edge.
// Reset clears the parser to expect a count line and loads the cap with
// 1000000000. When the receiver stalls with a result held and one byte in
// the input register, s_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module resp_command_array_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [rcap_pkg::NumW-1:0]   cfg_wr_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // data_byte
    input  logic                        s_tuser,   // restart
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rcap_pkg::TDataW-1:0] m_tdata,   // arg_byte, arg_number, zero pad
    output logic [rcap_pkg::KindW-1:0]  m_tuser,   // kind
    output logic                        m_tlast    // command_done
);

    logic                       in_valid;
    logic [rcap_pkg::ByteW-1:0] in_byte;
    logic                       in_restart;
    logic                       out_free;
    logic                       step;
    logic                       res_valid;
    rcap_pkg::result_t          res;
    rcap_pkg::result_t          res_q;

    assign step = in_valid && out_free;

    rcap_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_byte    (s_tdata),
        .s_restart (s_tuser),
        .consume   (step),
        .valid     (in_valid),
        .byte_q    (in_byte),
        .restart_q (in_restart)
    );

    rcap_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .in_byte     (in_byte),
        .in_restart  (in_restart),
        .res_valid   (res_valid),
        .res         (res)
    );

    rcap_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_valid),
        .res_in   (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_q    (res_q)
    );

    assign m_tdata = {{(rcap_pkg::TDataW - rcap_pkg::ByteW - rcap_pkg::NumW){1'b0}},
                      res_q.arg_number, res_q.arg_byte};
    assign m_tuser = res_q.kind;
    assign m_tlast = res_q.command_done;

    a_full_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are held");

    a_done_only_on_arg_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == rcap_pkg::KIND_ARG_END))
        else $error("command_done on a result that is not an argument end");

    a_byte_only_on_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != rcap_pkg::KIND_DATA) |-> (m_tdata[7:0] == 8'd0))
        else $error("arg_byte set on a non-data result");

    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid)) |-> $past(step))
        else $error("result appeared without a parser step");

endmodule

/* src/rcap_in_reg.sv */
// ----------------------------------------------------------------------------
// rcap_in_reg
// Input register: holds one request until the parser consumes it.
// ----------------------------------------------------------------------------
module rcap_in_reg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [rcap_pkg::ByteW-1:0] s_byte,
    input  logic                      s_restart,
    input  logic                      consume,
    output logic                      valid,
    output logic [rcap_pkg::ByteW-1:0] byte_q,
    output logic                      restart_q
);

    logic                       valid_reg;
    logic [rcap_pkg::ByteW-1:0] byte_reg;
    logic                       restart_reg;

    assign s_tready = !valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (consume) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg    <= s_byte;
            restart_reg <= s_restart;
        end
    end

    assign valid     = valid_reg;
    assign byte_q    = byte_reg;
    assign restart_q = restart_reg;

endmodule

/* src/rcap_parser.sv */
// ----------------------------------------------------------------------------
// rcap_parser
// Parser state and per-byte next-state logic; at most one result per byte.
// ----------------------------------------------------------------------------
module rcap_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [rcap_pkg::NumW-1:0]  cfg_wr_data,
    input  logic                       step,
    input  logic [rcap_pkg::ByteW-1:0] in_byte,
    input  logic                       in_restart,
    output logic                       res_valid,
    output rcap_pkg::result_t          res
);

    localparam logic [3:0] PH_HDR_STAR   = 4'd0;
    localparam logic [3:0] PH_HDR_NUM    = 4'd1;
    localparam logic [3:0] PH_HDR_LF     = 4'd2;
    localparam logic [3:0] PH_ARG_DOLLAR = 4'd3;
    localparam logic [3:0] PH_ARG_NUM    = 4'd4;
    localparam logic [3:0] PH_ARG_LF     = 4'd5;
    localparam logic [3:0] PH_DATA       = 4'd6;
    localparam logic [3:0] PH_TRAIL1     = 4'd7;
    localparam logic [3:0] PH_TRAIL2     = 4'd8;
    localparam logic [3:0] PH_ERROR      = 4'd9;

    logic [3:0]                phase_reg, phase_next, ph;
    logic                      digit_seen_reg, digit_seen_next, ds;
    logic [rcap_pkg::NumW-1:0] acc_reg, acc_next, acc;
    logic [rcap_pkg::NumW-1:0] args_left_reg, args_left_next, al;
    logic [rcap_pkg::NumW-1:0] bytes_left_reg, bytes_left_next, bl;
    logic [rcap_pkg::NumW-1:0] arg_counter_reg, arg_counter_next, ac;
    logic [rcap_pkg::NumW-1:0] max_number_reg;

    logic [rcap_pkg::AccW-1:0] acc_ext, acc_grown;
    logic [3:0]                digit_val;
    logic                      is_digit, is_cr, over_cap;
    logic [rcap_pkg::NumW-1:0] bl_dec;

    always_comb begin
        ph = in_restart ? PH_HDR_STAR : phase_reg;
        ds = in_restart ? 1'b0 : digit_seen_reg;
        acc = in_restart ? '0 : acc_reg;
        al = in_restart ? '0 : args_left_reg;
        bl = in_restart ? '0 : bytes_left_reg;
        ac = in_restart ? '0 : arg_counter_reg;
    end

    assign digit_val = in_byte[3:0];
    assign is_digit  = (in_byte >= rcap_pkg::CHAR_ZERO) && (in_byte <= rcap_pkg::CHAR_NINE);
    assign is_cr     = (in_byte == rcap_pkg::CHAR_CR);
    assign acc_ext   = {4'b0, acc};
    assign acc_grown = (acc_ext << 3) + (acc_ext << 1) + {{(rcap_pkg::AccW-4){1'b0}}, digit_val};
    assign over_cap  = acc_grown > {4'b0, max_number_reg};
    assign bl_dec    = bl - rcap_pkg::NumW'(1);

    always_comb begin
        phase_next       = ph;
        digit_seen_next  = ds;
        acc_next         = acc;
        args_left_next   = al;
        bytes_left_next  = bl;
        arg_counter_next = ac;
        res_valid        = 1'b0;
        res.kind         = rcap_pkg::KIND_ERROR;
        res.arg_byte     = '0;
        res.arg_number   = ac;
        res.command_done = 1'b0;
        case (ph)
            PH_HDR_STAR, PH_ARG_DOLLAR: begin
                if (in_byte != ((ph == PH_HDR_STAR) ? rcap_pkg::CHAR_STAR
                                                     : rcap_pkg::CHAR_DOLLAR)) begin
                    res_valid  = 1'b1;
                    phase_next = PH_ERROR;
                end else begin
                    digit_seen_next = 1'b0;
                    acc_next        = '0;
                    phase_next      = (ph == PH_HDR_STAR) ? PH_HDR_NUM : PH_ARG_NUM;
                end
            end
            PH_HDR_NUM, PH_ARG_NUM: begin
                if (is_cr) begin
                    if (!ds || (ph == PH_HDR_NUM && acc == '0)) begin
                        res_valid  = 1'b1;
                        phase_next = PH_ERROR;
                    end else begin
                        phase_next = (ph == PH_HDR_NUM) ? PH_HDR_LF : PH_ARG_LF;
                    end
                end else if (!is_digit || over_cap) begin
                    res_valid  = 1'b1;
                    phase_next = PH_ERROR;
                end else begin
                    acc_next        = acc_grown[rcap_pkg::NumW-1:0];
                    digit_seen_next = 1'b1;
                end
            end
            PH_HDR_LF, PH_ARG_LF: begin
                if (in_byte != rcap_pkg::CHAR_LF) begin
                    res_valid  = 1'b1;
                    phase_next = PH_ERROR;
                end else if (ph == PH_HDR_LF) begin
                    args_left_next   = acc;
                    arg_counter_next = '0;
                    phase_next       = PH_ARG_DOLLAR;
                end else begin
                    bytes_left_next = acc;
                    phase_next      = (acc == '0) ? PH_TRAIL1 : PH_DATA;
                end
            end
            PH_DATA: begin
                bytes_left_next = bl_dec;
                if (bl_dec == '0) begin
                    phase_next = PH_TRAIL1;
                end
                res_valid    = 1'b1;
                res.kind     = rcap_pkg::KIND_DATA;
                res.arg_byte = in_byte;
            end
            PH_TRAIL1: begin
                phase_next = PH_TRAIL2;
            end
            PH_TRAIL2: begin
                res_valid = 1'b1;
                res.kind  = rcap_pkg::KIND_ARG_END;
                if (al <= rcap_pkg::NumW'(1)) begin
                    res.command_done = 1'b1;
                    args_left_next   = '0;
                    arg_counter_next = '0;
                    phase_next       = PH_HDR_STAR;
                end else begin
                    args_left_next   = al - rcap_pkg::NumW'(1);
                    arg_counter_next = ac + rcap_pkg::NumW'(1);
                    phase_next       = PH_ARG_DOLLAR;
                end
            end
            default: begin
                phase_next = PH_ERROR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HDR_STAR;
            digit_seen_reg  <= 1'b0;
            acc_reg         <= '0;
            args_left_reg   <= '0;
            bytes_left_reg  <= '0;
            arg_counter_reg <= '0;
        end else if (step) begin
            phase_reg       <= phase_next;
            digit_seen_reg  <= digit_seen_next;
            acc_reg         <= acc_next;
            args_left_reg   <= args_left_next;
            bytes_left_reg  <= bytes_left_next;
            arg_counter_reg <= arg_counter_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_number_reg <= rcap_pkg::MaxNumberReset;
        end else if (cfg_wr_en) begin
            max_number_reg <= cfg_wr_data;
        end
    end

endmodule

/* src/rcap_out_reg.sv */
// ----------------------------------------------------------------------------
// rcap_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rcap_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  rcap_pkg::result_t res_in,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output rcap_pkg::result_t res_q
);

    logic              valid_reg;
    rcap_pkg::result_t res_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign res_q    = res_reg;

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the command array parser. A clocked driver feeds
// stream bytes in random bursts while the receiver stalls on its own pattern.
// Each accepted request runs through a cycle-free model of the parser, and
// the monitor compares every result against the oldest prediction. Directed
// bytes cover data extremes and protocol errors; random commands, broken
// commands and noise follow under several cap settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int StallLimit   = 1000;
    localparam int SettleCycles = 8;

    typedef enum logic [3:0] {
        WAIT_STAR,
        HDR_DIGITS,
        HDR_LF,
        WAIT_DOLLAR,
        LEN_DIGITS,
        LEN_LF,
        ARG_DATA,
        TRAIL_FIRST,
        TRAIL_SECOND,
        HALTED
    } parse_phase_t;

    typedef struct packed {
        logic [rcap_pkg::ByteW-1:0] data_byte;
        logic                       restart;
    } stream_byte_t;

    logic                        aclk;
    logic                        aresetn     = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [rcap_pkg::NumW-1:0]   cfg_wr_data = '0;
    logic                        s_tvalid    = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata     = '0;
    logic                        s_tuser     = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready    = 1'b1;
    logic [rcap_pkg::TDataW-1:0] m_tdata;
    logic [rcap_pkg::KindW-1:0]  m_tuser;
    logic                        m_tlast;

    resp_command_array_parser DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    stream_byte_t      stream_q[$];
    stream_byte_t      draft_q[$];
    rcap_pkg::result_t due_results[$];

    parse_phase_t              parse_ph   = WAIT_STAR;
    logic                      have_digit = 1'b0;
    logic [rcap_pkg::AccW-1:0] line_value = '0;
    logic [rcap_pkg::NumW-1:0] args_to_go = '0;
    logic [rcap_pkg::NumW-1:0] data_to_go = '0;
    logic [rcap_pkg::NumW-1:0] arg_idx    = '0;
    logic [rcap_pkg::NumW-1:0] cap        = rcap_pkg::MaxNumberReset;

    int          fail_count   = 0;
    int          stall_cycles = 0;
    int          pushed_total = 0;
    int          burst_left   = 0;
    int          gap_left     = 0;
    int          ready_tick   = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    bit          byte_taken   = 1'b0;
    bit          restart_next = 1'b0;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic bit flag_error(output rcap_pkg::result_t res);
        parse_ph         = HALTED;
        res.kind         = rcap_pkg::KIND_ERROR;
        res.arg_byte     = '0;
        res.arg_number   = arg_idx;
        res.command_done = 1'b0;
        return 1'b1;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic rst,
                                      output rcap_pkg::result_t res);
        res = '0;
        if (rst) begin
            parse_ph   = WAIT_STAR;
            have_digit = 1'b0;
            line_value = '0;
            args_to_go = '0;
            data_to_go = '0;
            arg_idx    = '0;
        end
        case (parse_ph)
            WAIT_STAR, WAIT_DOLLAR: begin
                if (b != ((parse_ph == WAIT_STAR) ? rcap_pkg::CHAR_STAR
                                                  : rcap_pkg::CHAR_DOLLAR))
                    return flag_error(res);
                have_digit = 1'b0;
                line_value = '0;
                parse_ph   = (parse_ph == WAIT_STAR) ? HDR_DIGITS : LEN_DIGITS;
                return 1'b0;
            end
            HDR_DIGITS, LEN_DIGITS: begin
                if (b == rcap_pkg::CHAR_CR) begin
                    if (!have_digit)
                        return flag_error(res);
                    if (parse_ph == HDR_DIGITS) begin
                        if (line_value == 0)
                            return flag_error(res);
                        parse_ph = HDR_LF;
                    end else begin
                        parse_ph = LEN_LF;
                    end
                    return 1'b0;
                end
                if (b < rcap_pkg::CHAR_ZERO || b > rcap_pkg::CHAR_NINE)
                    return flag_error(res);
                line_value = line_value * 10 + (b - rcap_pkg::CHAR_ZERO);
                have_digit = 1'b1;
                if (line_value > cap)
                    return flag_error(res);
                return 1'b0;
            end
            HDR_LF: begin
                if (b != rcap_pkg::CHAR_LF)
                    return flag_error(res);
                args_to_go = line_value[rcap_pkg::NumW-1:0];
                arg_idx    = '0;
                parse_ph   = WAIT_DOLLAR;
                return 1'b0;
            end
            LEN_LF: begin
                if (b != rcap_pkg::CHAR_LF)
                    return flag_error(res);
                data_to_go = line_value[rcap_pkg::NumW-1:0];
                parse_ph   = (data_to_go == 0) ? TRAIL_FIRST : ARG_DATA;
                return 1'b0;
            end
            ARG_DATA: begin
                data_to_go = data_to_go - 1'b1;
                if (data_to_go == 0)
                    parse_ph = TRAIL_FIRST;
                res.kind       = rcap_pkg::KIND_DATA;
                res.arg_byte   = b;
                res.arg_number = arg_idx;
                return 1'b1;
            end
            TRAIL_FIRST: begin
                parse_ph = TRAIL_SECOND;
                return 1'b0;
            end
            TRAIL_SECOND: begin
                res.kind         = rcap_pkg::KIND_ARG_END;
                res.arg_number   = arg_idx;
                res.command_done = (args_to_go <= 1);
                if (res.command_done) begin
                    args_to_go = '0;
                    arg_idx    = '0;
                    parse_ph   = WAIT_STAR;
                end else begin
                    args_to_go = args_to_go - 1'b1;
                    arg_idx    = arg_idx + 1'b1;
                    parse_ph   = WAIT_DOLLAR;
                end
                return 1'b1;
            end
            default: begin
                parse_ph = HALTED;
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        rcap_pkg::result_t pred;
        rcap_pkg::result_t got;
        rcap_pkg::result_t want;
        byte_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            if (parse_byte(s_tdata, s_tuser, pred))
                due_results = {due_results, pred};
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.kind         = m_tuser;
            got.arg_byte     = m_tdata[rcap_pkg::ByteW-1:0];
            got.arg_number   = m_tdata[rcap_pkg::ByteW +: rcap_pkg::NumW];
            got.command_done = m_tlast;
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d arg_number %0d", got.kind,
                       got.arg_number);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                if (got.kind != want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                    fail_count++;
                end
                if (got.arg_byte != want.arg_byte) begin
                    $error("arg_byte: expected %0d, actual %0d", want.arg_byte,
                           got.arg_byte);
                    fail_count++;
                end
                if (got.arg_number != want.arg_number) begin
                    $error("arg_number: expected %0d, actual %0d", want.arg_number,
                           got.arg_number);
                    fail_count++;
                end
                if (got.command_done != want.command_done) begin
                    $error("command_done: expected %0d, actual %0d", want.command_done,
                           got.command_done);
                    fail_count++;
                end
            end
        end
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else if (stream_q.size() != 0 || s_tvalid || due_results.size() != 0)
            stall_cycles++;
        if (stall_cycles >= StallLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        stream_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || byte_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (stream_q.size() != 0) begin
                nxt = stream_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data_byte;
                s_tuser  <= nxt.restart;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (ready_tick == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = 16'hFFFF;
                1:       ready_pattern = 16'($urandom);
                2:       ready_pattern = 16'($urandom) & 16'($urandom);
                default: ready_pattern = 16'($urandom) | 16'($urandom);
            endcase
            ready_pattern[0] = 1'b1;
        end
        m_tready   <= ready_pattern[ready_tick % 16];
        ready_tick = (ready_tick + 1) % 128;
    end

    task automatic put_byte(input logic [7:0] b, input bit r);
        stream_byte_t it;
        it.data_byte = b;
        it.restart   = r;
        draft_q = {draft_q, it};
    endtask

    task automatic put_line(input string s, input bit r);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i], r && i == 0);
    endtask

    task automatic put_crlf();
        put_byte(rcap_pkg::CHAR_CR, 1'b0);
        put_byte(rcap_pkg::CHAR_LF, 1'b0);
    endtask

    task automatic put_number(input longint v, input int zeros);
        repeat (zeros) put_byte(rcap_pkg::CHAR_ZERO, 1'b0);
        put_line($sformatf("%0d", v), 1'b0);
    endtask

    // Force a restart after anything that may leave the parser off track.
    task automatic commit_draft(input bit broken);
        int pos;
        if (draft_q.size() != 0 && restart_next)
            draft_q[0].restart = 1'b1;
        if (broken && draft_q.size() > 1) begin
            pos = $urandom_range(1, draft_q.size() - 1);
            case ($urandom_range(0, 2))
                0:       draft_q[pos].data_byte = 8'($urandom);
                1:       draft_q[pos].data_byte = rcap_pkg::CHAR_CR;
                default: while (draft_q.size() > pos) void'(draft_q.pop_back());
            endcase
        end
        restart_next = broken;
        pushed_total += draft_q.size();
        stream_q = {stream_q, draft_q};
        draft_q.delete();
    endtask

    task automatic add_command(input bit broken);
        int     nargs;
        int     len;
        int     off;
        longint count_val;
        nargs     = $urandom_range(1, 4);
        count_val = nargs;
        case ($urandom_range(0, 15))
            0: count_val = 0;
            1: begin
                off       = $urandom_range(0, 2);
                count_val = cap;
                count_val = count_val + off - 1;
                if (count_val < 0)
                    count_val = 0;
                nargs = 1;
            end
            default: ;
        endcase
        put_byte(rcap_pkg::CHAR_STAR, $urandom_range(0, 3) == 0);
        put_number(count_val, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
        put_crlf();
        for (int a = 0; a < nargs; a++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            put_byte(rcap_pkg::CHAR_DOLLAR, 1'b0);
            put_number(len, ($urandom_range(0, 7) == 0) ? 1 : 0);
            put_crlf();
            repeat (len) put_byte(8'($urandom), 1'b0);
            put_byte(8'($urandom), 1'b0);
            put_byte(8'($urandom), 1'b0);
        end
        commit_draft(broken || count_val != nargs);
    endtask

    task automatic add_random(input int n);
        int start;
        int pick;
        start = pushed_total;
        while (pushed_total - start < n) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 6))
                    put_byte(8'($urandom), $urandom_range(0, 3) == 0);
                commit_draft(1'b1);
            end else begin
                add_command(pick <= 2);
            end
        end
    endtask

    task automatic wait_idle();
        while (stream_q.size() != 0 || s_tvalid || due_results.size() != 0)
            @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic set_cap(input logic [rcap_pkg::NumW-1:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cap = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        set_cap(rcap_pkg::MaxNumberReset);

        put_line("*1", 1'b0);
        put_crlf();
        put_line("$2", 1'b0);
        put_crlf();
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        put_crlf();
        put_line("x", 1'b1);
        put_line("*", 1'b1);
        put_byte(rcap_pkg::CHAR_CR, 1'b0);
        put_line("*00", 1'b1);
        put_byte(rcap_pkg::CHAR_CR, 1'b0);
        put_line("*1", 1'b1);
        put_byte(rcap_pkg::CHAR_CR, 1'b0);
        put_line("Z", 1'b0);
        put_line("*/", 1'b1);
        commit_draft(1'b0);
        restart_next = 1'b1;
        add_random(220);
        wait_idle();

        set_cap({rcap_pkg::NumW{1'b1}});
        put_line("*1073741823", 1'b1);
        put_crlf();
        put_line("$1073741824", 1'b0);
        commit_draft(1'b0);
        restart_next = 1'b1;
        add_random(80);
        wait_idle();

        set_cap('0);
        add_random(30);
        wait_idle();

        set_cap(rcap_pkg::NumW'(5));
        put_line("*6", 1'b1);
        commit_draft(1'b0);
        restart_next = 1'b1;
        add_random(100);
        wait_idle();

        set_cap(rcap_pkg::MaxNumberReset);
        add_random(35);
        // hold the sender until every pending result is out
        wait_idle();
        add_random(35);
        wait_idle();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
src/rcap_pkg.sv
src/rcap_in_reg.sv
src/rcap_parser.sv
src/rcap_out_reg.sv
src/resp_command_array_parser.sv
bench/tb.sv
